### hdl/bpf_pkg.sv
// Shared types, constants and helpers for the path follower.
package bpf_pkg;

  localparam int SEGMENTS    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_WORDS = SEGMENTS * 12;
  localparam int ADDR_W      = $clog2(TABLE_WORDS);
  localparam int SEGP_W      = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int SEGA_W      = 9;
  localparam int ACC_W       = FRAC_BITS + 4;
  localparam int T_W         = FRAC_BITS + 1;
  localparam int INC_W       = FRAC_BITS + 8;
  localparam int SUM_W       = INC_W + 2;
  localparam int OPA_W       = 34;
  localparam int OPB_W       = 25;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 200;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_RSVD  = 2'd3
  } bpf_op_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_BEZIER = 2'd2,
    MODE_CHAIN  = 2'd3
  } bpf_mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_SPEED  = 2'd1,
    REG_SEGCNT = 2'd2,
    REG_RSVD   = 2'd3
  } bpf_reg_t;

  typedef struct packed {
    logic                    go;
    logic signed [OPA_W-1:0] opa;
    logic signed [OPB_W-1:0] opb;
    logic signed [31:0]      base;
  } bpf_mul_cmd_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [SEGA_W-1:0] seg,
                                                 input logic [1:0] pt,
                                                 input logic [1:0] ax);
    return ADDR_W'((int'(seg) * 4 + int'(pt)) * 3 + int'(ax));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    else if (v < -35'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    lo = -SUM_W'(64'sd1 <<< (ACC_W - 1));
    if (v > hi) return hi[ACC_W-1:0];
    else if (v < lo) return lo[ACC_W-1:0];
    else return v[ACC_W-1:0];
  endfunction

endpackage

### hdl/bpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bpf_mac.sv
// Shared multiplier with registered product and floor-shifted add.
module bpf_mac
  import bpf_pkg::*;
(
  input  logic                     clk,
  input  bpf_mul_cmd_t             cmd,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [31:0]       res
);

  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [31:0]      base_r;

  assign opa = cmd.opa;
  assign opb = cmd.opb;

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      prod   <= opa * opb;
      base_r <= cmd.base;
    end
  end

  assign res = base_r + signed'(prod[FRAC_BITS +: 32]);

endmodule

### hdl/bezier_path_follower.sv
// Path follower top level: sequencer, point table and shared multiplier.
// Load, start and reserved beats give no result; a tick with no motion goes
// straight to the output state. A moving tick computes the increment, then per
// axis does 4 table reads, the interpolation and the tangent, then finishes.
// Throughput: one beat in flight; a result held by m_tready low stalls in the last state.
// Reset (rst, synchronous) clears config, control and motion state, not the table.
module bezier_path_follower
  import bpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // opcode, delta, seg_index, point_index, axis, coord_value, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, moved, zero pad
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [23:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_INC_MUL, S_INC_ACC, S_READ, S_MUL, S_ADD, S_DIR, S_FINISH, S_OUT
  } state_t;

  state_t state;

  logic [1:0]  mode;
  logic [23:0] speed;
  logic [4:0]  seg_count;

  logic signed [ACC_W-1:0] acc;
  logic                    back;
  logic                    swapped;
  logic [SEGP_W-1:0]       seg_pos;
  logic                    active;

  logic [15:0]        delta;
  logic [T_W-1:0]     t;
  logic [1:0]         ax;
  logic [2:0]         rd_k;
  logic [2:0]         step;
  logic               moved;
  logic signed [31:0] p [4];
  logic signed [31:0] q [5];
  logic signed [31:0] pos [3];
  logic signed [31:0] dir [3];

  logic [1:0]  in_op;
  logic [15:0] in_delta;
  logic [3:0]  in_seg;
  logic [1:0]  in_pt;
  logic [1:0]  in_axis;
  logic [31:0] in_coord;

  assign in_op    = s_tdata[1:0];
  assign in_delta = s_tdata[17:2];
  assign in_seg   = s_tdata[21:18];
  assign in_pt    = s_tdata[23:22];
  assign in_axis  = s_tdata[25:24];
  assign in_coord = s_tdata[57:26];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  logic [SEGA_W-1:0] cnt;
  assign cnt = (SEGA_W'(seg_count) > SEGA_W'(SEGMENTS)) ? SEGA_W'(SEGMENTS)
                                                        : SEGA_W'(seg_count);

  // point table
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic [1:0]        phys;
  logic [SEGA_W-1:0] seg_sel;

  assign ram_we    = accept && (in_op == OP_LOAD) && (in_axis != 2'd3) &&
                     (SEGA_W'(in_seg) < SEGA_W'(SEGMENTS));
  assign ram_waddr = tbl_addr(SEGA_W'(in_seg), in_pt, in_axis);

  always_comb begin
    phys = rd_k[1:0];
    if (swapped && mode == MODE_BEZIER) begin
      phys = 2'd3 - rd_k[1:0];
    end else if (swapped && mode == MODE_LINEAR) begin
      phys = rd_k[1:0] ^ 2'd1;
    end
  end

  assign seg_sel   = (mode == MODE_CHAIN) ? SEGA_W'(seg_pos) : '0;
  assign ram_raddr = tbl_addr(seg_sel, phys, ax);

  bpf_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_coord),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier
  bpf_mul_cmd_t       cmd;
  logic signed [PROD_W-1:0] prod;
  logic signed [31:0] res;
  logic signed [31:0] a_op;
  logic signed [31:0] b_op;
  logic signed [32:0] diff;

  always_comb begin
    if (mode == MODE_LINEAR) begin
      a_op = p[0];
      b_op = p[1];
    end else begin
      unique case (step)
        3'd0:    begin a_op = p[0]; b_op = p[1]; end
        3'd1:    begin a_op = p[1]; b_op = p[2]; end
        3'd2:    begin a_op = p[2]; b_op = p[3]; end
        3'd3:    begin a_op = q[0]; b_op = q[1]; end
        3'd4:    begin a_op = q[1]; b_op = q[2]; end
        default: begin a_op = q[3]; b_op = q[4]; end
      endcase
    end
    diff = {b_op[31], b_op} - {a_op[31], a_op};
    cmd.go   = (state == S_INC_MUL) || (state == S_MUL);
    cmd.base = a_op;
    if (state == S_INC_MUL) begin
      cmd.opa = OPA_W'({18'b0, delta});
      cmd.opb = OPB_W'({1'b0, speed});
    end else begin
      cmd.opa = {diff[32], diff};
      cmd.opb = OPB_W'({{(OPB_W - T_W){1'b0}}, t});
    end
  end

  bpf_mac u_mac (
    .clk  (clk),
    .cmd  (cmd),
    .prod (prod),
    .res  (res)
  );

  // accumulator update
  logic [INC_W-1:0]        inc;
  logic signed [SUM_W-1:0] acc_ext;
  logic signed [SUM_W-1:0] inc_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [ACC_W-1:0] acc_new;
  logic [T_W-1:0]          t_new;
  logic signed [SUM_W-1:0] one_ext;
  logic signed [ACC_W-1:0] acc_bounce;

  assign inc     = prod[32 - FRAC_BITS +: INC_W];
  assign acc_ext = {{(SUM_W - ACC_W){acc[ACC_W-1]}}, acc};
  assign inc_ext = {2'b0, inc};
  assign sum     = (mode == MODE_CHAIN && back) ? acc_ext - inc_ext : acc_ext + inc_ext;
  assign acc_new = sat_acc(sum);
  assign t_new   = acc_new[ACC_W-1] ? '0 :
                   (acc_new > $signed({{(ACC_W - T_W){1'b0}}, T_ONE})) ? T_ONE
                                                                       : T_W'(acc_new);
  assign one_ext    = {{(SUM_W - T_W){1'b0}}, T_ONE};
  assign acc_bounce = sat_acc(one_ext - acc_ext);

  logic t_one;
  logic t_zero;
  assign t_one  = (t == T_ONE);
  assign t_zero = (t == '0);

  // tangent
  logic signed [34:0] dsrc;
  logic signed [34:0] dscaled;
  logic signed [31:0] dir_val;

  always_comb begin
    priority if (mode == MODE_LINEAR) begin
      dsrc = t_one ? 35'(p[0]) - 35'(p[1]) : 35'(p[1]) - 35'(p[0]);
      dscaled = dsrc;
    end else if (mode == MODE_BEZIER && t_one) begin
      dsrc = 35'(p[0]) - 35'(p[1]);
      dscaled = (dsrc <<< 1) + dsrc;
    end else begin
      dsrc = 35'(q[4]) - 35'(q[3]);
      dscaled = (dsrc <<< 1) + dsrc;
    end
    dir_val = sat32(dscaled);
  end

  logic [SEGA_W-1:0] seg_next;
  assign seg_next = SEGA_W'(seg_pos) + SEGA_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_NONE;
      speed     <= '0;
      seg_count <= '0;
      acc       <= '0;
      back      <= 1'b0;
      swapped   <= 1'b0;
      seg_pos   <= '0;
      active    <= 1'b0;
      m_tvalid  <= 1'b0;
      moved     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MODE:   mode      <= cfg_data[1:0];
          REG_SPEED:  speed     <= cfg_data;
          REG_SEGCNT: seg_count <= cfg_data[4:0];
          default:    ;
        endcase
      end
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_op)
              OP_START: begin
                acc     <= '0;
                back    <= 1'b0;
                swapped <= 1'b0;
                seg_pos <= '0;
                active  <= 1'b1;
              end
              OP_TICK: begin
                delta <= in_delta;
                if (!active || mode == MODE_NONE || (mode == MODE_CHAIN && cnt == '0)) begin
                  moved <= 1'b0;
                  state <= S_OUT;
                end else begin
                  state <= S_INC_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_INC_MUL: state <= S_INC_ACC;
        S_INC_ACC: begin
          acc <= acc_new;
          t   <= t_new;
          if (mode == MODE_CHAIN && SEGA_W'(seg_pos) >= cnt) begin
            seg_pos <= SEGP_W'(cnt - SEGA_W'(1));
          end
          ax    <= '0;
          rd_k  <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (rd_k != 3'd0) begin
            p[2'(rd_k - 3'd1)] <= ram_rdata;
          end
          if (rd_k == 3'd4) begin
            step  <= '0;
            state <= S_MUL;
          end else begin
            rd_k <= rd_k + 3'd1;
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: begin
          if (mode == MODE_LINEAR || step == 3'd5) begin
            pos[ax] <= res;
            state   <= S_DIR;
          end else begin
            q[step] <= res;
            step    <= step + 3'd1;
            state   <= S_MUL;
          end
        end
        S_DIR: begin
          dir[ax] <= dir_val;
          if (ax == 2'd2) begin
            state <= S_FINISH;
          end else begin
            ax    <= ax + 2'd1;
            rd_k  <= '0;
            state <= S_READ;
          end
        end
        S_FINISH: begin
          moved <= 1'b1;
          state <= S_OUT;
          if (mode == MODE_CHAIN) begin
            if (t_one || t_zero) begin
              if (!back) begin
                if (seg_next >= cnt) begin
                  back    <= 1'b1;
                  seg_pos <= SEGP_W'(cnt - SEGA_W'(1));
                  acc     <= ACC_W'(T_ONE);
                end else begin
                  seg_pos <= seg_pos + SEGP_W'(1);
                  acc     <= '0;
                end
              end else begin
                if (seg_pos == '0) begin
                  back <= 1'b0;
                  acc  <= '0;
                end else begin
                  seg_pos <= seg_pos - SEGP_W'(1);
                  acc     <= ACC_W'(T_ONE);
                end
              end
            end
          end else if (t_one) begin
            swapped <= !swapped;
            acc     <= acc_bounce;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
            if (moved) begin
              m_tdata <= {7'b0, 1'b1, dir[2], dir[1], dir[0], pos[2], pos[1], pos[0]};
            end else begin
              m_tdata <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/bpf_checker.sv
// Port-level checks for the path follower, bound to the top level.
module bpf_checker
  import bpf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_idle_tick_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[192] |-> m_tdata[191:0] == '0)
    else $error("result without motion carries nonzero fields");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1:0] == OP_TICK |=> !s_tready)
    else $error("ready after accepting a tick beat");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind bezier_path_follower bpf_checker u_bpf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
